### rtl/crw_pkg.sv
package crw_pkg;

  // Field widths
  localparam int COORD_WIDTH    = 13;
  localparam int RADIUS_WIDTH   = 10;
  localparam int SQRT_FRAC_BITS = 8;
  localparam int CTR_WIDTH      = 12;

  // Offsets from the center, their magnitudes and the sum of squares
  localparam int WIDE_CR = (COORD_WIDTH > CTR_WIDTH) ? COORD_WIDTH : CTR_WIDTH;
  localparam int OFS_W   = WIDE_CR + 2;
  localparam int MAG_W   = OFS_W - 1;
  localparam int SQ_W    = 2 * MAG_W + 1;
  localparam int EXT_W   = ((WIDE_CR > RADIUS_WIDTH) ? WIDE_CR : RADIUS_WIDTH) + 1;

  // Square-root unit: ROOT_SPC result bits per cycle
  localparam int ROOT_SPC   = 4;
  localparam int ROOT_PAIRS = (SQ_W + 1) / 2;
  localparam int ROOT_ITER  =
    ((ROOT_PAIRS + SQRT_FRAC_BITS + ROOT_SPC - 1) / ROOT_SPC) * ROOT_SPC;
  localparam int ROOT_IN_W  = 2 * (ROOT_ITER - SQRT_FRAC_BITS);
  localparam int ROOT_Y_W   = ROOT_ITER;
  localparam int ROOT_CYC   = ROOT_ITER / ROOT_SPC;
  localparam int ROOT_CNT_W = $clog2(ROOT_CYC + 1);
  localparam int ERR_W      = (ROOT_Y_W > RADIUS_WIDTH + SQRT_FRAC_BITS) ?
                              ROOT_Y_W : RADIUS_WIDTH + SQRT_FRAC_BITS;

  // Stream payloads
  localparam int IN_RAW_W   = 2 * CTR_WIDTH + RADIUS_WIDTH;
  localparam int IN_DATA_W  = ((IN_RAW_W + 7) / 8) * 8;
  localparam int OUT_RAW_W  = 2 * COORD_WIDTH;
  localparam int OUT_DATA_W = ((OUT_RAW_W + 7) / 8) * 8;

  // Register port
  localparam int APB_AW    = 3;
  localparam int APB_DW    = 32;
  localparam int REG_IDX_W = APB_AW - 2;
  localparam logic [REG_IDX_W-1:0] REG_CIRCLE_DOT = '0;

  // Request kinds
  localparam logic ACT_START = 1'b0;
  localparam logic ACT_STEP  = 1'b1;

  // Quadrants and candidate moves
  localparam logic [1:0] QD_RIGHT = 2'd0;
  localparam logic [1:0] QD_DOWN  = 2'd1;
  localparam logic [1:0] QD_LEFT  = 2'd2;
  localparam logic [1:0] QD_UP    = 2'd3;

  localparam logic [1:0] CAND_FIRST  = 2'd0;
  localparam logic [1:0] CAND_SECOND = 2'd1;
  localparam logic [1:0] CAND_LAST   = 2'd2;

  localparam logic [1:0] D_ZERO  = 2'b00;
  localparam logic [1:0] D_PLUS  = 2'b01;
  localparam logic [1:0] D_MINUS = 2'b11;

  function automatic logic [1:0] cand_dx(input logic [1:0] q, input logic [1:0] j);
    logic [1:0] d;
    unique case (q)
      QD_RIGHT: d = D_PLUS;
      QD_LEFT:  d = D_MINUS;
      default:  d = (j == CAND_FIRST) ? D_ZERO : ((j == CAND_SECOND) ? D_PLUS : D_MINUS);
    endcase
    return d;
  endfunction

  function automatic logic [1:0] cand_dy(input logic [1:0] q, input logic [1:0] j);
    logic [1:0] d;
    unique case (q)
      QD_DOWN: d = D_MINUS;
      QD_UP:   d = D_PLUS;
      default: d = (j == CAND_FIRST) ? D_ZERO : ((j == CAND_SECOND) ? D_MINUS : D_PLUS);
    endcase
    return d;
  endfunction

  // Microcode
  localparam int PC_W = 4;
  typedef logic [PC_W-1:0] pc_t;

  typedef enum logic [3:0] {
    OP_FETCH,
    OP_NOP,
    OP_LOAD,
    OP_EMIT_DOT,
    OP_EMIT_TOP,
    OP_QUAD,
    OP_SQX,
    OP_SQY,
    OP_ROOT_LD,
    OP_ROOT_WAIT,
    OP_CMP,
    OP_EMIT_STEP
  } op_e;

  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_ACCEPT,
    C_IS_STEP,
    C_NO_DOT,
    C_NOT_ACTIVE,
    C_ROOT_BUSY,
    C_J_MORE
  } cond_e;

  typedef struct packed {
    op_e   op;
    cond_e cond;
    logic  wait_out;
    pc_t   target;
  } uword_t;

  typedef struct packed {
    logic accept;
    logic is_step;
    logic no_dot;
    logic not_active;
    logic root_busy;
    logic j_more;
    logic out_full;
  } stat_t;

  typedef struct packed {
    op_e  op;
    logic fire;
  } ctrl_t;

  localparam pc_t PC_FETCH     = 4'd0;
  localparam pc_t PC_DISPATCH  = 4'd1;
  localparam pc_t PC_LOAD      = 4'd2;
  localparam pc_t PC_EMIT_DOT  = 4'd3;
  localparam pc_t PC_EMIT_TOP  = 4'd4;
  localparam pc_t PC_QUAD      = 4'd5;
  localparam pc_t PC_SQX       = 4'd6;
  localparam pc_t PC_SQY       = 4'd7;
  localparam pc_t PC_ROOT_LD   = 4'd8;
  localparam pc_t PC_ROOT_WAIT = 4'd9;
  localparam pc_t PC_CMP       = 4'd10;
  localparam pc_t PC_EMIT_STEP = 4'd11;
  localparam pc_t PC_LAST      = PC_EMIT_STEP;

  function automatic uword_t mk_word(input op_e op, input cond_e cond,
                                     input logic wait_out, input pc_t target);
    uword_t w;
    w.op       = op;
    w.cond     = cond;
    w.wait_out = wait_out;
    w.target   = target;
    return w;
  endfunction

  function automatic uword_t ucode_rom(input pc_t pc);
    uword_t w;
    unique case (pc)
      PC_FETCH:     w = mk_word(OP_FETCH,     C_NO_ACCEPT,  1'b0, PC_FETCH);
      PC_DISPATCH:  w = mk_word(OP_NOP,       C_IS_STEP,    1'b0, PC_QUAD);
      PC_LOAD:      w = mk_word(OP_LOAD,      C_NO_DOT,     1'b0, PC_EMIT_TOP);
      PC_EMIT_DOT:  w = mk_word(OP_EMIT_DOT,  C_NEVER,      1'b1, PC_FETCH);
      PC_EMIT_TOP:  w = mk_word(OP_EMIT_TOP,  C_ALWAYS,     1'b1, PC_FETCH);
      PC_QUAD:      w = mk_word(OP_QUAD,      C_NOT_ACTIVE, 1'b0, PC_FETCH);
      PC_SQX:       w = mk_word(OP_SQX,       C_NEVER,      1'b0, PC_FETCH);
      PC_SQY:       w = mk_word(OP_SQY,       C_NEVER,      1'b0, PC_FETCH);
      PC_ROOT_LD:   w = mk_word(OP_ROOT_LD,   C_NEVER,      1'b0, PC_FETCH);
      PC_ROOT_WAIT: w = mk_word(OP_ROOT_WAIT, C_ROOT_BUSY,  1'b0, PC_ROOT_WAIT);
      PC_CMP:       w = mk_word(OP_CMP,       C_J_MORE,     1'b0, PC_SQX);
      PC_EMIT_STEP: w = mk_word(OP_EMIT_STEP, C_ALWAYS,     1'b1, PC_FETCH);
      default:      w = mk_word(OP_NOP,       C_ALWAYS,     1'b0, PC_FETCH);
    endcase
    return w;
  endfunction

endpackage

### rtl/circle_rasterizer_walk.sv
// Circle rasterizer, nearest-pixel walk.
// Requests arrive on the s_axis channel. tuser = 0 starts a circle from the
// center and radius in tdata and emits the top pixel, preceded by the center
// pixel when register circle_dot (APB address 0, bit 0) is set. tuser = 1
// advances one pixel clockwise and emits it; such a request is dropped with
// no result while no circle is running. Pixels leave on m_axis: tlast marks
// the last pixel of a request, tuser flags the pixel that closes the circle.
// A start request passes fetch, dispatch, load and the emit steps. A step
// request computes three candidate distances, each by squaring the x and
// y offsets, a load and a wait in the shared square-root unit (four result
// bits per cycle) plus a compare, around fetch, quadrant and emit steps.
// One request is in work at a time; s_axis_tready is high only while the
// sequencer waits for a request, which may overlap a pixel still waiting
// in the output register.
// When m_axis_tready is low the pixel holds in the output register and the
// sequencer stalls on its next emit. Reset clears the running circle, the
// output register and circle_dot.
module circle_rasterizer_walk import crw_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // APB register port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_AW-1:0]     paddr,
  input  logic [APB_DW-1:0]     pwdata,
  output logic [APB_DW-1:0]     prdata,
  output logic                  pready,
  // requests
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // center_x, center_y, radius, zero pad
  input  logic                  s_axis_tuser,   // action
  // pixels
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,   // point_x, point_y, zero pad
  output logic                  m_axis_tlast,   // last_of_run
  output logic                  m_axis_tuser    // finished
);

  ctrl_t ctrl;
  stat_t stat;

  logic circle_dot_q;

  logic                    req_action_q;
  logic [CTR_WIDTH-1:0]    req_cx_q, req_cy_q;
  logic [RADIUS_WIDTH-1:0] req_rad_q;

  logic [CTR_WIDTH-1:0]    ctr_x_q, ctr_y_q;
  logic [RADIUS_WIDTH-1:0] rad_q;
  logic [COORD_WIDTH-1:0]  cur_x_q, cur_y_q;
  logic                    active_q;

  logic signed [OFS_W-1:0] ox_q, oy_q;
  logic [1:0]              q_q, j_q, best_q;
  logic [ERR_W-1:0]        best_err_q;
  logic [2*MAG_W-1:0]      prod_q, sqx_q;

  logic                    out_valid_q;
  logic [COORD_WIDTH-1:0]  out_x_q, out_y_q;
  logic                    out_last_q, out_fin_q;

  logic accept;
  logic cfg_wr;
  logic fire_load, fire_quad, fire_sqx, fire_sqy, fire_root, fire_cmp, fire_step;
  logic emit;

  // ---------------------------------------------------------------- APB
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;
  assign prdata = (paddr[APB_AW-1:2] == REG_CIRCLE_DOT) ? APB_DW'(circle_dot_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      circle_dot_q <= 1'b0;
    end else if (cfg_wr && (paddr[APB_AW-1:2] == REG_CIRCLE_DOT)) begin
      circle_dot_q <= pwdata[0];
    end
  end

  // ---------------------------------------------------------------- sequencer
  assign s_axis_tready = (ctrl.op == OP_FETCH);
  assign accept        = s_axis_tvalid & s_axis_tready;

  assign fire_load = ctrl.fire && (ctrl.op == OP_LOAD);
  assign fire_quad = ctrl.fire && (ctrl.op == OP_QUAD);
  assign fire_sqx  = ctrl.fire && (ctrl.op == OP_SQX);
  assign fire_sqy  = ctrl.fire && (ctrl.op == OP_SQY);
  assign fire_root = ctrl.fire && (ctrl.op == OP_ROOT_LD);
  assign fire_cmp  = ctrl.fire && (ctrl.op == OP_CMP);
  assign fire_step = ctrl.fire && (ctrl.op == OP_EMIT_STEP);
  assign emit      = ctrl.fire && ((ctrl.op == OP_EMIT_DOT) || (ctrl.op == OP_EMIT_TOP) ||
                                   (ctrl.op == OP_EMIT_STEP));

  logic                root_busy;
  logic [ROOT_Y_W-1:0] root_y;
  logic [SQ_W-1:0]     radicand;

  assign stat.accept     = accept;
  assign stat.is_step    = (req_action_q == ACT_STEP);
  assign stat.no_dot     = !circle_dot_q;
  assign stat.not_active = !active_q;
  assign stat.root_busy  = root_busy;
  assign stat.j_more     = (j_q != CAND_LAST);
  assign stat.out_full   = out_valid_q & !m_axis_tready;

  crw_ucode u_ucode (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctrl_o (ctrl)
  );

  assign radicand = SQ_W'(sqx_q) + SQ_W'(prod_q);

  crw_root u_root (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (fire_root),
    .radicand_i (radicand),
    .busy_o     (root_busy),
    .root_o     (root_y)
  );

  // ---------------------------------------------------------------- request capture
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_action_q <= s_axis_tuser;
      req_cx_q     <= s_axis_tdata[CTR_WIDTH-1:0];
      req_cy_q     <= s_axis_tdata[2*CTR_WIDTH-1:CTR_WIDTH];
      req_rad_q    <= s_axis_tdata[2*CTR_WIDTH+RADIUS_WIDTH-1:2*CTR_WIDTH];
    end
  end

  // ---------------------------------------------------------------- start
  logic signed [EXT_W-1:0] ld_cx, ld_cy, ld_top, dot_y;

  assign ld_cx  = EXT_W'($signed(req_cx_q));
  assign ld_cy  = EXT_W'($signed(req_cy_q));
  assign ld_top = ld_cy + $signed(EXT_W'(req_rad_q));
  assign dot_y  = EXT_W'($signed(ctr_y_q));

  // ---------------------------------------------------------------- quadrant
  logic signed [OFS_W-1:0] ox_c, oy_c;
  logic                    steep;
  logic [1:0]              quad_c;

  assign ox_c = OFS_W'($signed(cur_x_q)) - OFS_W'($signed(ctr_x_q));
  assign oy_c = OFS_W'($signed(cur_y_q)) - OFS_W'($signed(ctr_y_q));

  always_comb begin
    priority if (ox_c == 0) begin
      steep = 1'b1;
    end else if (ox_c > 0) begin
      steep = (oy_c >= ox_c) || (oy_c < -ox_c);
    end else begin
      steep = (oy_c <= ox_c) || (oy_c > -ox_c);
    end
    if (steep) begin
      quad_c = (oy_c > 0) ? QD_RIGHT : QD_LEFT;
    end else begin
      quad_c = (ox_c > 0) ? QD_DOWN : QD_UP;
    end
  end

  // ---------------------------------------------------------------- squares
  logic signed [OFS_W-1:0] off_c;
  logic [MAG_W-1:0]        mag_c;
  logic [2*MAG_W-1:0]      mag_sq;

  assign off_c  = (ctrl.op == OP_SQY) ? oy_q + OFS_W'($signed(cand_dy(q_q, j_q)))
                                      : ox_q + OFS_W'($signed(cand_dx(q_q, j_q)));
  assign mag_c  = off_c[OFS_W-1] ? MAG_W'(-off_c) : MAG_W'(off_c);
  assign mag_sq = mag_c * mag_c;

  // ---------------------------------------------------------------- distance error
  logic [ERR_W-1:0] y_ext, tgt, err;

  assign y_ext = ERR_W'(root_y);
  assign tgt   = ERR_W'({rad_q, {SQRT_FRAC_BITS{1'b0}}});
  assign err   = (y_ext >= tgt) ? y_ext - tgt : tgt - y_ext;

  // ---------------------------------------------------------------- move
  logic [COORD_WIDTH-1:0]  nx_c, ny_c;
  logic signed [OFS_W-1:0] nx_off, ny_off;
  logic                    step_fin;

  assign nx_c     = cur_x_q + COORD_WIDTH'($signed(cand_dx(q_q, best_q)));
  assign ny_c     = cur_y_q + COORD_WIDTH'($signed(cand_dy(q_q, best_q)));
  assign nx_off   = OFS_W'($signed(nx_c)) - OFS_W'($signed(ctr_x_q));
  assign ny_off   = OFS_W'($signed(ny_c)) - OFS_W'($signed(ctr_y_q));
  assign step_fin = (nx_off == OFS_W'(-1)) && (ny_off > 0);

  // ---------------------------------------------------------------- circle state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctr_x_q  <= '0;
      ctr_y_q  <= '0;
      rad_q    <= '0;
      cur_x_q  <= '0;
      cur_y_q  <= '0;
      active_q <= 1'b0;
    end else if (fire_load) begin
      ctr_x_q  <= req_cx_q;
      ctr_y_q  <= req_cy_q;
      rad_q    <= req_rad_q;
      cur_x_q  <= ld_cx[COORD_WIDTH-1:0];
      cur_y_q  <= ld_top[COORD_WIDTH-1:0];
      active_q <= (req_rad_q != '0);
    end else if (fire_step) begin
      cur_x_q <= nx_c;
      cur_y_q <= ny_c;
      if (step_fin) begin
        active_q <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- step datapath
  always_ff @(posedge clk_i) begin
    if (fire_quad) begin
      ox_q <= ox_c;
      oy_q <= oy_c;
      q_q  <= quad_c;
      j_q  <= CAND_FIRST;
    end
    if (fire_sqx) begin
      prod_q <= mag_sq;
    end
    if (fire_sqy) begin
      sqx_q  <= prod_q;
      prod_q <= mag_sq;
    end
    if (fire_cmp) begin
      // keep the earlier candidate on a tie
      if ((j_q == CAND_FIRST) || (err < best_err_q)) begin
        best_err_q <= err;
        best_q     <= j_q;
      end
      if (j_q != CAND_LAST) begin
        j_q <= j_q + 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      unique case (ctrl.op)
        OP_EMIT_DOT: begin
          out_x_q    <= cur_x_q;
          out_y_q    <= dot_y[COORD_WIDTH-1:0];
          out_last_q <= 1'b0;
          out_fin_q  <= 1'b0;
        end
        OP_EMIT_TOP: begin
          out_x_q    <= cur_x_q;
          out_y_q    <= cur_y_q;
          out_last_q <= 1'b1;
          out_fin_q  <= (rad_q == '0);
        end
        default: begin
          out_x_q    <= nx_c;
          out_y_q    <= ny_c;
          out_last_q <= 1'b1;
          out_fin_q  <= step_fin;
        end
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_DATA_W'({out_y_q, out_x_q});
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_fin_q;

  // ---------------------------------------------------------------- checks
  a_fin_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> m_axis_tlast)
    else $error("closing pixel not marked as last of its request");

  a_step_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_step |-> active_q)
    else $error("step pixel emitted with no circle running");

  a_cursor_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(fire_load || fire_step) |=> ($stable(cur_x_q) && $stable(cur_y_q)))
    else $error("cursor moved outside a load or a step emit");

endmodule

### rtl/crw_root.sv
module crw_root import crw_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [SQ_W-1:0]     radicand_i,
  output logic                busy_o,
  output logic [ROOT_Y_W-1:0] root_o
);

  logic                  busy_q, busy_d;
  logic [ROOT_CNT_W-1:0] cnt_q, cnt_d;
  logic [ROOT_IN_W-1:0]  s_q, s_d;
  logic [ROOT_Y_W+1:0]   rem_q, rem_d;
  logic [ROOT_Y_W-1:0]   y_q, y_d;

  // ROOT_SPC restoring square-root steps per cycle
  always_comb begin
    logic [ROOT_IN_W-1:0] s_v;
    logic [ROOT_Y_W+1:0]  rem_v;
    logic [ROOT_Y_W+1:0]  trial_v;
    logic [ROOT_Y_W-1:0]  y_v;
    logic [1:0]           pair_v;
    s_v   = s_q;
    rem_v = rem_q;
    y_v   = y_q;
    for (int k = 0; k < ROOT_SPC; k++) begin
      pair_v  = s_v[ROOT_IN_W-1 -: 2];
      s_v     = s_v << 2;
      rem_v   = {rem_v[ROOT_Y_W-1:0], pair_v};
      trial_v = {y_v, 2'b01};
      if (rem_v >= trial_v) begin
        rem_v = rem_v - trial_v;
        y_v   = {y_v[ROOT_Y_W-2:0], 1'b1};
      end else begin
        y_v   = {y_v[ROOT_Y_W-2:0], 1'b0};
      end
    end

    busy_d = busy_q;
    cnt_d  = cnt_q;
    s_d    = s_q;
    rem_d  = rem_q;
    y_d    = y_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = ROOT_CNT_W'(ROOT_CYC);
      s_d    = ROOT_IN_W'(radicand_i);
      rem_d  = '0;
      y_d    = '0;
    end else if (busy_q) begin
      busy_d = (cnt_q != ROOT_CNT_W'(1));
      cnt_d  = cnt_q - 1'b1;
      s_d    = s_v;
      rem_d  = rem_v;
      y_d    = y_v;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s_q   <= s_d;
    rem_q <= rem_d;
    y_q   <= y_d;
  end

  assign busy_o = busy_q;
  assign root_o = y_q;

  a_cnt_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (cnt_q != '0))
    else $error("root unit busy with an exhausted step count");

endmodule

### rtl/crw_ucode.sv
module crw_ucode import crw_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  stat_t stat_i,
  output ctrl_t ctrl_o
);

  pc_t    pc_q, pc_d;
  uword_t word;
  logic   hold;
  logic   taken;

  assign word = ucode_rom(pc_q);
  // hold an emitting word while the output register is occupied
  assign hold = word.wait_out & stat_i.out_full;

  always_comb begin
    unique case (word.cond)
      C_NEVER:      taken = 1'b0;
      C_ALWAYS:     taken = 1'b1;
      C_NO_ACCEPT:  taken = !stat_i.accept;
      C_IS_STEP:    taken = stat_i.is_step;
      C_NO_DOT:     taken = stat_i.no_dot;
      C_NOT_ACTIVE: taken = stat_i.not_active;
      C_ROOT_BUSY:  taken = stat_i.root_busy;
      C_J_MORE:     taken = stat_i.j_more;
    endcase
  end

  always_comb begin
    priority if (hold) begin
      pc_d = pc_q;
    end else if (taken) begin
      pc_d = word.target;
    end else begin
      pc_d = pc_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= PC_FETCH;
    end else begin
      pc_q <= pc_d;
    end
  end

  assign ctrl_o.op   = word.op;
  assign ctrl_o.fire = !hold;

  a_pc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pc_q <= PC_LAST)
    else $error("step counter left the program");

  a_root_idle_at_fetch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pc_q == PC_FETCH) |-> !stat_i.root_busy)
    else $error("square-root unit still busy when a new request is taken");

endmodule
